// ===== src/drift_mass_redistribution_core_assert.svh =====
// Assertion macros for the drift mass redistribution core.
`ifndef DRIFT_MASS_REDISTRIBUTION_CORE_ASSERT_SVH
`define DRIFT_MASS_REDISTRIBUTION_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DRM_ASSERT_IMPL(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed: ante implies cons");
`define DRM_ASSERT_NEXT(label, clock, rstn, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: ante implies cons next cycle");
`else
`define DRM_ASSERT_IMPL(label, clock, rstn, ante, cons)
`define DRM_ASSERT_NEXT(label, clock, rstn, ante, cons)
`endif
`endif

// ===== src/drm_pkg.sv =====
// Shared types and constants of the drift mass redistribution core.
package drm_pkg;

	localparam int EXP_SUM_W  = 32;
	localparam int MASS_SUM_W = 48;
	localparam int MAG_W      = 16;
	localparam int QUO_W      = 32;
	localparam int HALF_W     = MASS_SUM_W / 2;

	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_DIST  = 1'b1;

	typedef struct packed {
		logic               operation;
		logic               first;
		logic signed [15:0] exposure;
		logic        [31:0] eroded_mass;
		logic        [31:0] precip_in;
	} drm_in_t;

	typedef struct packed {
		logic signed [32:0] deposition;
		logic        [31:0] precip_out;
		logic               no_drift;
		logic               saturated;
	} drm_out_t;

	typedef struct packed {
		logic start;
	} drm_div_ctl_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} drm_div_sts_t;

endpackage

// ===== src/drm_muldiv.sv =====
// Iterative scale-and-divide unit: mag * mass_sum / exposure_sum, one bit per cycle.
module drm_muldiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  drm_pkg::drm_div_ctl_t             ctl,
	input  logic [drm_pkg::MAG_W-1:0]         mag,
	input  logic [drm_pkg::MASS_SUM_W-1:0]    mass_sum,
	input  logic [drm_pkg::EXP_SUM_W-1:0]     divisor,
	output drm_pkg::drm_div_sts_t             sts,
	output logic [drm_pkg::QUO_W-1:0]         quotient
);
	import drm_pkg::*;

	localparam int NUM_W  = 64;
	localparam int PROD_W = MAG_W + HALF_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ADD,
		ST_CHK,
		ST_DIV
	} state_t;

	state_t                  state_q;
	logic [4:0]              cnt_q;
	logic                    done_q;
	logic                    ovf_q;
	logic [MAG_W-1:0]        mag_q;
	logic [MASS_SUM_W-1:0]   ms_q;
	logic [EXP_SUM_W-1:0]    div_q;
	logic [PROD_W-1:0]       plo_q;
	logic [PROD_W-1:0]       phi_q;
	logic [NUM_W-1:0]        num_q;

	logic [HALF_W-1:0]       mul_b;
	logic [PROD_W-1:0]       prod;
	logic [EXP_SUM_W:0]      opnd_a;
	logic [EXP_SUM_W+1:0]    diff;
	logic                    ge;

	// one multiplier, fed with the low or high half of the mass sum
	assign mul_b = (state_q == ST_MUL_HI) ? ms_q[MASS_SUM_W-1:HALF_W] : ms_q[HALF_W-1:0];
	assign prod  = PROD_W'(mag_q) * PROD_W'(mul_b);

	// one subtractor: overflow check on the upper half, then restoring steps
	assign opnd_a = (state_q == ST_CHK) ? {1'b0, num_q[NUM_W-1:QUO_W]}
	                                    : {num_q[NUM_W-1:QUO_W], num_q[QUO_W-1]};
	assign diff   = {1'b0, opnd_a} - {2'b00, div_q};
	assign ge     = !diff[EXP_SUM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_ADD;
				ST_ADD:    state_q <= ST_CHK;
				ST_CHK: begin
					cnt_q <= '0;
					if (ge) begin
						// quotient would not fit in 32 bits
						done_q  <= 1'b1;
						ovf_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						done_q  <= 1'b1;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					mag_q <= mag;
					ms_q  <= mass_sum;
					div_q <= divisor;
				end
			end
			ST_MUL_LO: plo_q <= prod;
			ST_MUL_HI: phi_q <= prod;
			ST_ADD:    num_q <= NUM_W'(plo_q) + (NUM_W'(phi_q) << HALF_W);
			ST_DIV: begin
				num_q <= {(ge ? diff[EXP_SUM_W-1:0] : opnd_a[EXP_SUM_W-1:0]),
				          num_q[QUO_W-2:0], ge};
			end
			default: ;
		endcase
	end

	assign sts.done = done_q;
	assign sts.ovf  = ovf_q;
	assign quotient = num_q[QUO_W-1:0];

endmodule

// ===== src/drift_mass_redistribution_core.sv =====
// Top level of the drift mass redistribution core: sums, sequencer and result register.
// An accumulate transaction completes in the cycle it is accepted and busy never rises.
// A distribute transaction for an unsheltered cell, or while the exposure sum is zero,
// shows its result in the cycle after acceptance, also without raising busy. A distribute
// transaction for a sheltered cell runs through the multiply/divide unit: two
// 16x24 multiplies, one add, an overflow check and 32 restoring divide steps on one
// subtractor, so busy stays high and no new transaction is accepted until the unit is
// done, skipping the divide steps when the quotient overflows 32 bits. Results
// are shown for one cycle with done high; the receiver must take them then.
`include "drift_mass_redistribution_core_assert.svh"

module drift_mass_redistribution_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  drm_pkg::drm_in_t item,
	output logic             done,
	output drm_pkg::drm_out_t result
);
	import drm_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_WAIT
	} state_t;

	state_t                 state_q;
	logic                   done_q;
	drm_out_t               result_q;
	logic [EXP_SUM_W-1:0]   exp_sum_q;
	logic [MASS_SUM_W-1:0]  mass_sum_q;
	logic [31:0]            pin_q;

	logic                   accept;
	logic                   sheltered;
	logic [MAG_W-1:0]       mag;
	logic [EXP_SUM_W-1:0]   exp_base;
	logic [EXP_SUM_W:0]     exp_add;
	logic [MASS_SUM_W-1:0]  mass_base;
	logic [MASS_SUM_W:0]    mass_add;
	logic                   need_div;
	drm_div_ctl_t           div_ctl;
	drm_div_sts_t           div_sts;
	logic [QUO_W-1:0]       quotient;
	logic [32:0]            psum;

	assign accept    = start && !busy;
	assign sheltered = item.exposure[15];
	assign mag       = sheltered ? (~item.exposure + 16'sd1) : '0;

	assign exp_base  = item.first ? '0 : exp_sum_q;
	assign exp_add   = {1'b0, exp_base} + (EXP_SUM_W+1)'(mag);
	assign mass_base = item.first ? '0 : mass_sum_q;
	assign mass_add  = {1'b0, mass_base} + (MASS_SUM_W+1)'(item.eroded_mass);

	assign need_div      = accept && (item.operation == OP_DIST) && sheltered
	                       && (exp_sum_q != '0);
	assign div_ctl.start = need_div;

	drm_muldiv u_muldiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.mag      (mag),
		.mass_sum (mass_sum_q),
		.divisor  (exp_sum_q),
		.sts      (div_sts),
		.quotient (quotient)
	);

	assign psum = {1'b0, pin_q} + {1'b0, quotient};

	// running sums, saturating at all ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_sum_q  <= '0;
			mass_sum_q <= '0;
		end else if (accept && (item.operation == OP_ACCUM)) begin
			exp_sum_q  <= exp_add[EXP_SUM_W] ? '1 : exp_add[EXP_SUM_W-1:0];
			mass_sum_q <= mass_add[MASS_SUM_W] ? '1 : mass_add[MASS_SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			result_q <= '0;
			pin_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (item.operation == OP_DIST)) begin
						if (exp_sum_q == '0) begin
							done_q              <= 1'b1;
							result_q.deposition <= '0;
							result_q.precip_out <= item.precip_in;
							result_q.no_drift   <= 1'b1;
							result_q.saturated  <= 1'b0;
						end else if (!sheltered) begin
							done_q              <= 1'b1;
							result_q.deposition <= 33'sd0 - $signed({1'b0, item.eroded_mass});
							result_q.precip_out <= item.precip_in;
							result_q.no_drift   <= 1'b0;
							result_q.saturated  <= 1'b0;
						end else begin
							// hold precip until the quotient arrives
							pin_q   <= item.precip_in;
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (div_sts.done) begin
						done_q            <= 1'b1;
						result_q.no_drift <= 1'b0;
						if (div_sts.ovf) begin
							result_q.deposition <= $signed({1'b0, 32'hFFFF_FFFF});
							result_q.precip_out <= '1;
							result_q.saturated  <= 1'b1;
						end else begin
							result_q.deposition <= $signed({1'b0, quotient});
							result_q.precip_out <= psum[32] ? '1 : psum[31:0];
							result_q.saturated  <= psum[32];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = (state_q == ST_WAIT);
	assign done   = done_q;
	assign result = result_q;

	`DRM_ASSERT_IMPL(a_flags_exclusive, clk, arst_n, done, !(result.no_drift && result.saturated))
	`DRM_ASSERT_IMPL(a_unit_done_busy, clk, arst_n, div_sts.done, busy)
	`DRM_ASSERT_NEXT(a_accum_silent, clk, arst_n, accept && (item.operation == OP_ACCUM), !done)
	`DRM_ASSERT_IMPL(a_sat_clips, clk, arst_n, done && result.saturated, result.precip_out == '1)

endmodule
